@@ rtl/ibt_pkg.sv @@
// Shared constants, codes and types of the indent and bracket tracker.
`timescale 1ns / 1ps
`default_nettype none
package ibt_pkg;

  localparam int INDENT_WIDTH_DEF  = 4;
  localparam int BRACKET_DEPTH_DEF = 16;
  localparam int INDENT_DEPTH_DEF  = 32;
  localparam int MAX_RUN           = 64;
  localparam int COL_W             = 8;
  localparam int COL_SPAN          = 1 << COL_W;

  localparam logic OP_LINE  = 1'b0;
  localparam logic OP_TOKEN = 1'b1;

  localparam logic [3:0] TK_ENDLINE     = 4'd1;
  localparam logic [3:0] TK_OPEN_PAREN  = 4'd2;
  localparam logic [3:0] TK_OPEN_BRACE  = 4'd5;
  localparam logic [3:0] TK_CLOSE_PAREN = 4'd6;
  localparam logic [3:0] TK_CLOSE_BRACE = 4'd9;

  typedef enum logic [1:0] {
    RK_NONE   = 2'd0,
    RK_INDENT = 2'd1,
    RK_DEDENT = 2'd2,
    RK_ERROR  = 2'd3
  } rkind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_INDENT     = 3'd1,
    ERR_UNEXPECTED = 3'd2,
    ERR_MISMATCH   = 3'd3,
    ERR_CLOSE_COL  = 3'd4,
    ERR_CONTENT    = 3'd5,
    ERR_OVERFLOW   = 3'd6
  } err_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [COL_W-1:0] column;
    logic             hanging;
  } bentry_t;

  // Marks every depth that is a whole number of indent steps.
  function automatic logic [COL_SPAN-1:0] multiple_mask(input int w);
    logic [COL_SPAN-1:0] m;
    int                  i;
    m = '0;
    for (i = 0; i < COL_SPAN; i = i + w) begin
      m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

@@ rtl/ibt_in_if.sv @@
// Input event channel of the indent and bracket tracker.
`timescale 1ns / 1ps
`default_nettype none
interface ibt_in_if;
  import ibt_pkg::*;

  logic             valid;
  logic             ready;
  logic             operation;
  logic [3:0]       token_kind;
  logic [COL_W-1:0] column;

  modport source (output valid, operation, token_kind, column, input ready);
  modport sink   (input valid, operation, token_kind, column, output ready);
endinterface
`default_nettype wire

@@ rtl/ibt_out_if.sv @@
// Result channel of the indent and bracket tracker.
`timescale 1ns / 1ps
`default_nettype none
interface ibt_out_if;
  import ibt_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, result_kind, error_code, last, input ready);
  modport sink   (input valid, result_kind, error_code, last, output ready);
endinterface
`default_nettype wire

@@ rtl/indent_bracket_tracker.sv @@
// Offside-rule indentation and bracket tracker: top level.
// An event is taken in S_IDLE and handled in S_EXEC once the output slot is free; the next
// waits for S_IDLE again. A close that leaves brackets open adds S_BFILL, each popped
// level S_POP and S_POP_LD; an INDENT or DEDENT run gives one beat a cycle unless stalled.
// Each stack is read through one registered memory port. Reset (synchronous, rst_n low) sets
// the indent count to 1 and clears the bracket count, flags, the halt and the output valid.
`timescale 1ns / 1ps
`default_nettype none
module indent_bracket_tracker #(
  parameter int INDENT_WIDTH  = ibt_pkg::INDENT_WIDTH_DEF,
  parameter int BRACKET_DEPTH = ibt_pkg::BRACKET_DEPTH_DEF,
  parameter int INDENT_DEPTH  = ibt_pkg::INDENT_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ibt_in_if.sink    in_ch,
  ibt_out_if.source out_ch
);
  import ibt_pkg::*;

  // Widths of the stack counts (which must hold the depth), the indexes and the run count.
  localparam int BCW   = $clog2(BRACKET_DEPTH + 1);
  localparam int BIW   = $clog2(BRACKET_DEPTH);
  localparam int ICW   = $clog2(INDENT_DEPTH + 1);
  localparam int IIW   = $clog2(INDENT_DEPTH);
  localparam int CNT_W = $clog2(MAX_RUN);

  localparam logic [COL_W-1:0]    W_STEP    = COL_W'(INDENT_WIDTH);
  localparam logic [COL_SPAN-1:0] MULT_MASK = multiple_mask(INDENT_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_POP_LD,
    S_EMIT,
    S_BFILL
  } state_t;

  // Sequencer and latched event.
  state_t           state_r, state_nxt;
  logic             op_r, op_nxt;
  logic [3:0]       kind_r, kind_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             halted_r, halted_nxt;

  // Tracker state. The top entry of each stack is cached in registers; the
  // memories behind them are written through and read only to refill a cache
  // after a pop.
  logic [BCW-1:0]   bcount_r, bcount_nxt;
  logic [ICW-1:0]   icount_r, icount_nxt;
  logic [COL_W-1:0] top_r, top_nxt;
  bentry_t          btop_r, btop_nxt;
  logic             mh_r, mh_nxt;
  logic             cce_r, cce_nxt;

  // Run generator: the remaining distance is counted down by one indent step per emitted beat.
  logic [COL_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  rkind_t           run_kind_r, run_kind_nxt;
  logic             run_last;

  // Output register.
  logic             ov_r, ov_nxt;
  rkind_t           ok_r, ok_nxt;
  err_t             oe_r, oe_nxt;
  logic             ol_r, ol_nxt;
  logic             slot_free;

  // Indent level memory: entry zero is the base level and is never written,
  // so a read of it is forced to zero.
  logic [COL_W-1:0] imem [INDENT_DEPTH];
  logic             iwe;
  logic [IIW-1:0]   iwaddr;
  logic [IIW-1:0]   iraddr;
  logic [COL_W-1:0] irdata_r;
  logic             izero_r, izero_nxt;

  // Bracket record memory.
  bentry_t          bmem [BRACKET_DEPTH];
  logic             bwe;
  logic [BIW-1:0]   bwaddr;
  bentry_t          bwdata;
  logic [BIW-1:0]   braddr;
  bentry_t          brdata_r;

  // Event decode. Kinds above the last close fall through as ordinary tokens.
  logic             is_open;
  logic             is_close;
  logic             is_endline;
  logic [3:0]       open_off;
  logic [3:0]       close_off;
  logic [COL_W:0]   content_col;
  logic [COL_W-1:0] open_col;
  logic             close_col_bad;

  assign is_open    = (kind_r >= TK_OPEN_PAREN) && (kind_r <= TK_OPEN_BRACE);
  assign is_close   = (kind_r >= TK_CLOSE_PAREN) && (kind_r <= TK_CLOSE_BRACE);
  assign is_endline = (kind_r == TK_ENDLINE);
  assign open_off   = kind_r - TK_OPEN_PAREN;
  assign close_off  = kind_r - TK_CLOSE_PAREN;

  // A hanging bracket wants its content at the stored column, a wrapped one
  // one indent step in from it.
  assign content_col = {1'b0, btop_r.column} +
                       (btop_r.hanging ? '0 : {1'b0, W_STEP});
  // The stored column is one past the bracket, saturating at the right edge.
  assign open_col    = (col_r == '1) ? col_r : col_r + COL_W'(1);
  assign close_col_bad = btop_r.hanging ? (col_r < btop_r.column)
                                        : (col_r != btop_r.column);

  assign run_last  = (rem_r == W_STEP) || (cnt_r == CNT_W'(MAX_RUN - 1));
  assign slot_free = !ov_r || out_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = ov_r;
  assign out_ch.result_kind = ok_r;
  assign out_ch.error_code  = oe_r;
  assign out_ch.last        = ol_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    kind_nxt     = kind_r;
    col_nxt      = col_r;
    halted_nxt   = halted_r;
    bcount_nxt   = bcount_r;
    icount_nxt   = icount_r;
    top_nxt      = top_r;
    btop_nxt     = btop_r;
    mh_nxt       = mh_r;
    cce_nxt      = cce_r;
    rem_nxt      = rem_r;
    cnt_nxt      = cnt_r;
    run_kind_nxt = run_kind_r;
    izero_nxt    = izero_r;
    ov_nxt       = ov_r && !out_ch.ready;
    ok_nxt       = ok_r;
    oe_nxt       = oe_r;
    ol_nxt       = ol_r;
    iwe          = 1'b0;
    iwaddr       = IIW'(icount_r);
    iraddr       = '0;
    bwe          = 1'b0;
    bwaddr       = '0;
    bwdata       = btop_r;
    braddr       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.operation;
          kind_nxt = in_ch.token_kind;
          col_nxt  = in_ch.column;
          // Once halted, every beat is taken and dropped.
          if (!halted_r) begin
            state_nxt = S_EXEC;
          end
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          // Default outcome: a single plain acceptance beat.
          ov_nxt    = 1'b1;
          ok_nxt    = RK_NONE;
          oe_nxt    = ERR_NONE;
          ol_nxt    = 1'b1;
          state_nxt = S_IDLE;
          if (op_r == OP_LINE) begin
            if (bcount_r != '0) begin
              if ({1'b0, col_r} != content_col) begin
                cce_nxt = 1'b1;
              end
            end else if (!MULT_MASK[col_r]) begin
              ok_nxt     = RK_ERROR;
              oe_nxt     = ERR_INDENT;
              halted_nxt = 1'b1;
            end else if (col_r < top_r) begin
              ov_nxt       = ov_r && !out_ch.ready;
              rem_nxt      = top_r - col_r;
              cnt_nxt      = '0;
              run_kind_nxt = RK_DEDENT;
              state_nxt    = S_POP;
            end else if (col_r > top_r) begin
              if (icount_r == ICW'(INDENT_DEPTH)) begin
                ok_nxt     = RK_ERROR;
                oe_nxt     = ERR_OVERFLOW;
                halted_nxt = 1'b1;
              end else begin
                ov_nxt       = ov_r && !out_ch.ready;
                iwe          = 1'b1;
                top_nxt      = col_r;
                icount_nxt   = icount_r + ICW'(1);
                rem_nxt      = col_r - top_r;
                cnt_nxt      = '0;
                run_kind_nxt = RK_INDENT;
                state_nxt    = S_EMIT;
              end
            end
          end else if (is_open) begin
            if (bcount_r == BCW'(BRACKET_DEPTH)) begin
              ok_nxt     = RK_ERROR;
              oe_nxt     = ERR_OVERFLOW;
              halted_nxt = 1'b1;
            end else begin
              btop_nxt.kind    = open_off[1:0];
              btop_nxt.column  = open_col;
              btop_nxt.hanging = 1'b1;
              bwe        = 1'b1;
              bwaddr     = BIW'(bcount_r);
              bwdata     = btop_nxt;
              bcount_nxt = bcount_r + BCW'(1);
              mh_nxt     = 1'b1;
            end
          end else if (is_close) begin
            if (bcount_r == '0) begin
              ok_nxt     = RK_ERROR;
              oe_nxt     = ERR_UNEXPECTED;
              halted_nxt = 1'b1;
            end else if (btop_r.kind != close_off[1:0]) begin
              ok_nxt     = RK_ERROR;
              oe_nxt     = ERR_MISMATCH;
              halted_nxt = 1'b1;
            end else if (close_col_bad) begin
              ok_nxt     = RK_ERROR;
              oe_nxt     = ERR_CLOSE_COL;
              halted_nxt = 1'b1;
            end else begin
              cce_nxt    = 1'b0;
              mh_nxt     = 1'b0;
              bcount_nxt = bcount_r - BCW'(1);
              if (bcount_r > BCW'(1)) begin
                braddr    = BIW'(bcount_r - BCW'(2));
                state_nxt = S_BFILL;
              end
            end
          end else if ((bcount_r != '0) && mh_r && is_endline) begin
            // Line break straight after an open bracket: the bracket wraps
            // and takes the current indent level as its column.
            btop_nxt.hanging = 1'b0;
            btop_nxt.column  = top_r;
            bwe    = 1'b1;
            bwaddr = BIW'(bcount_r - BCW'(1));
            bwdata = btop_nxt;
            mh_nxt = 1'b0;
          end else if ((bcount_r != '0) && cce_r) begin
            ok_nxt     = RK_ERROR;
            oe_nxt     = ERR_CONTENT;
            halted_nxt = 1'b1;
          end else begin
            mh_nxt = 1'b0;
          end
        end
      end

      S_POP: begin
        // Pop levels deeper than the new line, one per read of the memory.
        if ((icount_r > ICW'(1)) && (top_r > col_r)) begin
          iraddr    = IIW'(icount_r - ICW'(2));
          izero_nxt = (icount_r == ICW'(2));
          state_nxt = S_POP_LD;
        end else begin
          // Dedent to a depth between levels: the depth becomes a level if the stack has room.
          if ((top_r < col_r) && (icount_r < ICW'(INDENT_DEPTH))) begin
            iwe        = 1'b1;
            top_nxt    = col_r;
            icount_nxt = icount_r + ICW'(1);
          end
          state_nxt = S_EMIT;
        end
      end

      S_POP_LD: begin
        top_nxt    = izero_r ? '0 : irdata_r;
        icount_nxt = icount_r - ICW'(1);
        state_nxt  = S_POP;
      end

      S_EMIT: begin
        if (slot_free) begin
          ov_nxt  = 1'b1;
          ok_nxt  = run_kind_r;
          oe_nxt  = ERR_NONE;
          ol_nxt  = run_last;
          rem_nxt = rem_r - W_STEP;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (run_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_BFILL: begin
        btop_nxt  = brdata_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      halted_r <= 1'b0;
      bcount_r <= '0;
      icount_r <= ICW'(1);
      top_r    <= '0;
      mh_r     <= 1'b0;
      cce_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      halted_r <= halted_nxt;
      bcount_r <= bcount_nxt;
      icount_r <= icount_nxt;
      top_r    <= top_nxt;
      mh_r     <= mh_nxt;
      cce_r    <= cce_nxt;
      ov_r     <= ov_nxt;
    end
    op_r       <= op_nxt;
    kind_r     <= kind_nxt;
    col_r      <= col_nxt;
    btop_r     <= btop_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    run_kind_r <= run_kind_nxt;
    izero_r    <= izero_nxt;
    ok_r       <= ok_nxt;
    oe_r       <= oe_nxt;
    ol_r       <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (iwe) begin
      imem[iwaddr] <= col_r;
    end
    irdata_r <= imem[iraddr];
  end

  always_ff @(posedge clk) begin
    if (bwe) begin
      bmem[bwaddr] <= bwdata;
    end
    brdata_r <= bmem[braddr];
  end

endmodule
`default_nettype wire

@@ rtl/ibt_checker.sv @@
// Port-level checks of the indent and bracket tracker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ibt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_result_kind,
  input wire logic [2:0] out_error_code,
  input wire logic       out_last
);
  import ibt_pkg::*;

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind)
      && $stable(out_error_code) && $stable(out_last))
    else $error("result beat dropped or changed while stalled");

  // An error beat carries a real code and closes its event.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_ERROR) |-> out_last && (out_error_code != ERR_NONE))
    else $error("error beat without code or without last");

  // Beats that are not errors carry no code.
  a_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind != RK_ERROR) |-> (out_error_code == ERR_NONE))
    else $error("error code on a non-error beat");

  // A plain acceptance is always the only beat of its event.
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_NONE) |-> out_last)
    else $error("acceptance beat without last");

  // After a delivered error the block is halted and shows nothing more.
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && (out_result_kind == RK_ERROR) |=> !out_valid)
    else $error("result beat after an error");

endmodule

bind indent_bracket_tracker ibt_checker u_ibt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_result_kind (out_ch.result_kind),
  .out_error_code  (out_ch.error_code),
  .out_last        (out_ch.last)
);
`default_nettype wire
